// ===== rtl/core/orbit_camera_pose_update_defines.svh =====
// assertion macros shared by the orbit camera pose update rtl
`ifndef ORBIT_CAMERA_POSE_UPDATE_DEFINES_SVH
`define ORBIT_CAMERA_POSE_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define OPU_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error("%m: check failed");
`define OPU_ASSERT_RST(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("%m: reset check failed");
`else
`define OPU_ASSERT(lbl, ck, rs, prop)
`define OPU_ASSERT_RST(lbl, ck, prop)
`endif
`endif

// ===== rtl/core/opu_pkg.sv =====
// types, constants and arithmetic helpers for the orbit camera pose update
package opu_pkg;

  localparam int TRIG_STAGES = 16;
  localparam int CW = 38;
  localparam int ZW = 34;
  localparam int GW = CW + 25;
  localparam int NSTAGE = 4 * TRIG_STAGES + 12;

  localparam logic signed [24:0] INV_GAIN = 25'sd10188014;
  localparam logic signed [30:0] RAD_TO_BAM = 31'sd683565276;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(64'sd1073741824);

  localparam logic [31:0] ATAN_BAM [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [3:0] {
    OP_DIFF, OP_MUL, OP_MOVE, OP_VEC, OP_GMUL, OP_V1DONE, OP_V2DONE,
    OP_ROT, OP_R1DONE, OP_R2DONE, OP_FINAL
  } op_t;

  typedef struct packed {
    logic signed [31:0]     px;
    logic signed [31:0]     py;
    logic signed [31:0]     pz;
    logic signed [31:0]     ax;
    logic signed [31:0]     ay;
    logic signed [31:0]     az;
    logic signed [15:0]     stf;
    logic signed [15:0]     adv;
    logic signed [15:0]     yaw;
    logic signed [15:0]     pit;
    logic signed [15:0]     fdel;
    logic [15:0]            fov;
    logic signed [32:0]     dx;
    logic signed [32:0]     dy;
    logic signed [32:0]     dz;
    logic signed [46:0]     yprod;
    logic signed [46:0]     pprod;
    logic [31:0]            yawb;
    logic [31:0]            pitb;
    logic signed [48:0]     p0;
    logic signed [48:0]     p1;
    logic signed [48:0]     p2;
    logic signed [48:0]     p3;
    logic signed [48:0]     p4;
    logic signed [CW-1:0]   cx;
    logic signed [CW-1:0]   cy;
    logic signed [ZW-1:0]   cz;
    logic                   zf;
    logic signed [GW-1:0]   gx;
    logic signed [GW-1:0]   gy;
    logic [31:0]            theta;
    logic signed [CW-1:0]   ox;
    logic signed [CW-1:0]   oy;
    logic signed [CW-1:0]   oz;
  } item_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    return ATAN_BAM[i];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [39:0] hi;
    logic signed [39:0] lo;
    hi = 40'sd2147483647;
    lo = -40'sd2147483648;
    if (v > hi) return 32'sh7FFFFFFF;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  // gain correction rounding: add half, shift right 24
  function automatic logic signed [CW-1:0] gain_round(input logic signed [GW-1:0] g);
    logic signed [GW-1:0] t;
    t = g + GW'(64'sd8388608);
    return CW'(t >>> 24);
  endfunction

  // vectoring preparation, folding left half plane into the right
  function automatic item_t vec_pre(input item_t a, input logic signed [CW-1:0] x,
                                    input logic signed [CW-1:0] y);
    item_t r;
    r = a;
    r.zf = (x == '0) && (y == '0);
    if (x < 0) begin
      if (y >= 0) begin
        r.cx = y;
        r.cy = -x;
        r.cz = QUARTER;
      end else begin
        r.cx = -y;
        r.cy = x;
        r.cz = -QUARTER;
      end
    end else begin
      r.cx = x;
      r.cy = y;
      r.cz = '0;
    end
    return r;
  endfunction

  // rotation preparation, bringing the residual within a quarter turn
  function automatic item_t rot_pre(input item_t a, input logic signed [CW-1:0] m,
                                    input logic [31:0] ang);
    item_t r;
    logic signed [ZW-1:0] res;
    r = a;
    res = ZW'($signed(ang));
    if (res > QUARTER) begin
      r.cx = '0;
      r.cy = m;
      r.cz = res - QUARTER;
    end else if (res < -QUARTER) begin
      r.cx = '0;
      r.cy = -m;
      r.cz = res + QUARTER;
    end else begin
      r.cx = m;
      r.cy = '0;
      r.cz = res;
    end
    return r;
  endfunction

  function automatic op_t stage_op(input int s);
    int k;
    k = TRIG_STAGES;
    if (s == 0) return OP_DIFF;
    if (s == 1) return OP_MUL;
    if (s == 2) return OP_MOVE;
    if (s < 3 + k) return OP_VEC;
    if (s == 3 + k) return OP_GMUL;
    if (s == 4 + k) return OP_V1DONE;
    if (s < 5 + 2 * k) return OP_VEC;
    if (s == 5 + 2 * k) return OP_GMUL;
    if (s == 6 + 2 * k) return OP_V2DONE;
    if (s < 7 + 3 * k) return OP_ROT;
    if (s == 7 + 3 * k) return OP_GMUL;
    if (s == 8 + 3 * k) return OP_R1DONE;
    if (s < 9 + 4 * k) return OP_ROT;
    if (s == 9 + 4 * k) return OP_GMUL;
    if (s == 10 + 4 * k) return OP_R2DONE;
    return OP_FINAL;
  endfunction

  function automatic logic [4:0] stage_iter(input int s);
    int k;
    k = TRIG_STAGES;
    if (s >= 3 && s < 3 + k) return 5'(s - 3);
    if (s >= 5 + k && s < 5 + 2 * k) return 5'(s - 5 - k);
    if (s >= 7 + 2 * k && s < 7 + 3 * k) return 5'(s - 7 - 2 * k);
    if (s >= 9 + 3 * k && s < 9 + 4 * k) return 5'(s - 9 - 3 * k);
    return '0;
  endfunction

endpackage

// ===== rtl/core/orbit_camera_pose_update.sv =====
// Orbit camera pose update: moves a camera along and across its view offset,
// turns the offset in yaw and pitch through CORDIC, and returns new position,
// focus and field of view. Fully pipelined: one request per cycle while the
// output is not stalled. The pipeline holds the four chains of
// TRIG_STAGES CORDIC stages (two vectoring, two rotation) with their gain
// multiplies. Any stage that is empty takes the next request, so bubbles
// close up under output back-pressure.
`include "orbit_camera_pose_update_defines.svh"
module orbit_camera_pose_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] aim_x,
  input  logic signed [31:0] aim_y,
  input  logic signed [31:0] aim_z,
  input  logic signed [15:0] strafe,
  input  logic signed [15:0] advance,
  input  logic signed [15:0] yaw_step,
  input  logic signed [15:0] pitch_step,
  input  logic signed [15:0] fov_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_pos_x,
  output logic signed [31:0] new_pos_y,
  output logic signed [31:0] new_pos_z,
  output logic signed [31:0] new_aim_x,
  output logic signed [31:0] new_aim_y,
  output logic signed [31:0] new_aim_z,
  output logic [15:0]        new_fov
);

  localparam int N = opu_pkg::NSTAGE;

  logic [15:0] start_fov;
  opu_pkg::item_t items [N+1];
  logic vld [N+1];
  logic rdy [N+1];

  // field of view base register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_fov <= '0;
    end else if (cfg_wr_en) begin
      start_fov <= cfg_wr_data;
    end
  end

  // request entry
  always_comb begin
    items[0] = '0;
    items[0].px = pos_x;
    items[0].py = pos_y;
    items[0].pz = pos_z;
    items[0].ax = aim_x;
    items[0].ay = aim_y;
    items[0].az = aim_z;
    items[0].stf = strafe;
    items[0].adv = advance;
    items[0].yaw = yaw_step;
    items[0].pit = pitch_step;
    items[0].fdel = fov_offset;
  end

  assign vld[0] = in_valid;
  assign in_ready = rdy[0];
  assign rdy[N] = out_ready;

  // stage chain
  for (genvar s = 0; s < N; s++) begin : g_stage
    opu_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .op        (opu_pkg::stage_op(s)),
      .iter      (opu_pkg::stage_iter(s)),
      .start_fov (start_fov),
      .in_valid  (vld[s]),
      .in_ready  (rdy[s]),
      .in_item   (items[s]),
      .out_valid (vld[s+1]),
      .out_ready (rdy[s+1]),
      .out_item  (items[s+1])
    );
  end

  // result
  assign out_valid = vld[N];
  assign new_pos_x = items[N].px;
  assign new_pos_y = items[N].py;
  assign new_pos_z = items[N].pz;
  assign new_aim_x = items[N].ax;
  assign new_aim_y = items[N].ay;
  assign new_aim_z = items[N].az;
  assign new_fov   = items[N].fov;

  // an empty output stage never blocks the input
  `OPU_ASSERT(a_free_out_accepts, clk, rst, !out_valid |-> in_ready)
  // reset empties the pipeline
  `OPU_ASSERT_RST(a_reset_empties, clk, $past(rst) |-> !out_valid)

endmodule

// ===== rtl/core/opu_stage.sv =====
// one pipeline stage: a step of the pose math plus its holding register
module opu_stage (
  input  logic             clk,
  input  logic             rst,
  input  opu_pkg::op_t     op,
  input  logic [4:0]       iter,
  input  logic [15:0]      start_fov,
  input  logic             in_valid,
  output logic             in_ready,
  input  opu_pkg::item_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output opu_pkg::item_t   out_item
);

  opu_pkg::item_t item_next;
  logic signed [17:0] fsum;
  logic signed [47:0] angt;
  logic signed [47:0] pangt;
  logic signed [50:0] sx;
  logic signed [50:0] sy;
  logic signed [50:0] sz;
  logic signed [opu_pkg::CW-1:0] xs;
  logic signed [opu_pkg::CW-1:0] ys;
  logic signed [opu_pkg::CW-1:0] gr;
  logic signed [opu_pkg::CW-1:0] gr2;
  logic signed [opu_pkg::ZW-1:0] at;
  logic [31:0] ang;

  // step logic selected by the stage's role
  always_comb begin
    item_next = in_item;
    fsum = $signed({2'b00, start_fov}) + 18'(in_item.fdel);
    angt = 48'(in_item.yprod) + 48'sd8192;
    pangt = 48'(in_item.pprod) + 48'sd8192;
    sx = 51'(in_item.p0) + 51'(in_item.p1) + 51'sd8192;
    sy = 51'(in_item.p2) + 51'sd8192;
    sz = 51'(in_item.p4) - 51'(in_item.p3) + 51'sd8192;
    xs = in_item.cx >>> iter;
    ys = in_item.cy >>> iter;
    gr = opu_pkg::gain_round(in_item.gx);
    gr2 = opu_pkg::gain_round(in_item.gy);
    at = opu_pkg::ZW'(opu_pkg::atan_bam(iter));
    ang = in_item.zf ? 32'h0 : in_item.cz[31:0];
    unique case (op)
      opu_pkg::OP_DIFF: begin
        item_next.dx = 33'(in_item.ax) - 33'(in_item.px);
        item_next.dy = 33'(in_item.ay) - 33'(in_item.py);
        item_next.dz = 33'(in_item.az) - 33'(in_item.pz);
        item_next.yprod = 47'(in_item.yaw) * 47'(opu_pkg::RAD_TO_BAM);
        item_next.pprod = 47'(in_item.pit) * 47'(opu_pkg::RAD_TO_BAM);
        if (fsum < 0) item_next.fov = '0;
        else if (fsum > 18'sd65535) item_next.fov = 16'hFFFF;
        else item_next.fov = fsum[15:0];
      end
      opu_pkg::OP_MUL: begin
        item_next.p0 = 49'(in_item.dx) * 49'(in_item.adv);
        item_next.p1 = 49'(in_item.stf) * 49'(in_item.dz);
        item_next.p2 = 49'(in_item.dy) * 49'(in_item.adv);
        item_next.p3 = 49'(in_item.stf) * 49'(in_item.dx);
        item_next.p4 = 49'(in_item.dz) * 49'(in_item.adv);
        item_next.yawb = angt[45:14];
        item_next.pitb = pangt[45:14];
      end
      opu_pkg::OP_MOVE: begin
        item_next = opu_pkg::vec_pre(in_item, opu_pkg::CW'(in_item.dx),
                                     opu_pkg::CW'(in_item.dz));
        item_next.px = opu_pkg::sat32(40'(in_item.px) + 40'(sx >>> 14));
        item_next.py = opu_pkg::sat32(40'(in_item.py) + 40'(sy >>> 14));
        item_next.pz = opu_pkg::sat32(40'(in_item.pz) + 40'(sz >>> 14));
      end
      opu_pkg::OP_VEC: begin
        if (in_item.cy >= 0) begin
          item_next.cx = in_item.cx + ys;
          item_next.cy = in_item.cy - xs;
          item_next.cz = in_item.cz + at;
        end else begin
          item_next.cx = in_item.cx - ys;
          item_next.cy = in_item.cy + xs;
          item_next.cz = in_item.cz - at;
        end
      end
      opu_pkg::OP_GMUL: begin
        item_next.gx = opu_pkg::GW'(in_item.cx) * opu_pkg::GW'(opu_pkg::INV_GAIN);
        item_next.gy = opu_pkg::GW'(in_item.cy) * opu_pkg::GW'(opu_pkg::INV_GAIN);
      end
      opu_pkg::OP_V1DONE: begin
        item_next = opu_pkg::vec_pre(in_item, opu_pkg::CW'(in_item.dy), gr);
        item_next.theta = ang + in_item.yawb;
      end
      opu_pkg::OP_V2DONE: begin
        item_next = opu_pkg::rot_pre(in_item, gr, ang + in_item.pitb);
      end
      opu_pkg::OP_ROT: begin
        if (in_item.cz >= 0) begin
          item_next.cx = in_item.cx - ys;
          item_next.cy = in_item.cy + xs;
          item_next.cz = in_item.cz - at;
        end else begin
          item_next.cx = in_item.cx + ys;
          item_next.cy = in_item.cy - xs;
          item_next.cz = in_item.cz + at;
        end
      end
      opu_pkg::OP_R1DONE: begin
        item_next = opu_pkg::rot_pre(in_item, gr2, in_item.theta);
        item_next.oy = gr;
      end
      opu_pkg::OP_R2DONE: begin
        item_next.ox = gr;
        item_next.oz = gr2;
      end
      opu_pkg::OP_FINAL: begin
        item_next.ax = opu_pkg::sat32(40'(in_item.px) + 40'(in_item.ox));
        item_next.ay = opu_pkg::sat32(40'(in_item.py) + 40'(in_item.oy));
        item_next.az = opu_pkg::sat32(40'(in_item.pz) + 40'(in_item.oz));
      end
      default: item_next = in_item;
    endcase
  end

  // stage takes a request when empty or when its contents move on
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

// ===== dv/tb_orbit_camera_pose_update.sv =====
// self-checking testbench for the orbit camera pose update pipeline
module tb_orbit_camera_pose_update;

  localparam int NSTG = 16;
  localparam int PIPE_DEPTH = 4 * NSTG + 12;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [15:0] stf;
    logic signed [15:0] adv;
    logic signed [15:0] yaw;
    logic signed [15:0] pit;
    logic signed [15:0] fdel;
  } pose_req_t;

  typedef struct packed {
    logic [31:0] npx;
    logic [31:0] npy;
    logic [31:0] npz;
    logic [31:0] nax;
    logic [31:0] nay;
    logic [31:0] naz;
    logic [15:0] fov;
  } pose_res_t;

  // binary-angle arctangent steps, one per cordic stage
  localparam logic [31:0] ARCTAN_STEP [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  pose_req_t drv_req = '0;
  pose_res_t dut_res;

  pose_req_t pending_reqs[$];
  pose_res_t expected_poses[$];
  logic [15:0] fov_base = '0;
  bit quiet = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int mismatches = 0;

  always #2 clk = ~clk;

  orbit_camera_pose_update DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(drv_req.px), .pos_y(drv_req.py), .pos_z(drv_req.pz),
    .aim_x(drv_req.ax), .aim_y(drv_req.ay), .aim_z(drv_req.az),
    .strafe(drv_req.stf), .advance(drv_req.adv),
    .yaw_step(drv_req.yaw), .pitch_step(drv_req.pit), .fov_offset(drv_req.fdel),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_pos_x(dut_res.npx), .new_pos_y(dut_res.npy), .new_pos_z(dut_res.npz),
    .new_aim_x(dut_res.nax), .new_aim_y(dut_res.nay), .new_aim_z(dut_res.naz),
    .new_fov(dut_res.fov)
  );

  // ---------------- pose predictor ----------------

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unscale_gain(input longint v);
    return (v * 64'sd10188014 + 64'sd8388608) >>> 24;
  endfunction

  function automatic logic [31:0] rad_to_angle(input longint d);
    longint t;
    t = (d * 64'sd683565276 + 64'sd8192) >>> 14;
    return t[31:0];
  endfunction

  // vectoring: magnitude and binary angle of (x, y)
  task automatic polar_of(input longint x0, input longint y0,
                          output longint mag, output logic [31:0] ang);
    longint x, y, z, t, xs, ys;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      ang = '0;
      return;
    end
    // fold the left half plane by a quarter turn
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sd1073741824;
      end else begin
        x = -y; y = t; z = -64'sd1073741824;
      end
    end
    for (int i = 0; i < NSTG; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(ARCTAN_STEP[i[4:0]]);
      end else begin
        x -= ys; y += xs; z -= longint'(ARCTAN_STEP[i[4:0]]);
      end
    end
    mag = x;
    ang = z[31:0];
  endtask

  // rotation: turn (m, 0) by a binary angle
  task automatic rotate_by(input longint m, input logic [31:0] ang,
                           output longint cx, output longint sy);
    longint x, y, r, t, xs, ys;
    x = m;
    y = 0;
    r = longint'($signed(ang));
    if (r > 64'sd1073741824) begin
      t = x; x = -y; y = t; r -= 64'sd1073741824;
    end else if (r < -64'sd1073741824) begin
      t = x; x = y; y = -t; r += 64'sd1073741824;
    end
    for (int i = 0; i < NSTG; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (r >= 0) begin
        x -= ys; y += xs; r -= longint'(ARCTAN_STEP[i[4:0]]);
      end else begin
        x += ys; y -= xs; r += longint'(ARCTAN_STEP[i[4:0]]);
      end
    end
    cx = x;
    sy = y;
  endtask

  task automatic predict_pose(input pose_req_t q, output pose_res_t e);
    longint px, py, pz, dx, dy, dz, stf, adv;
    longint npx, npy, npz, mag, rho, rad, c, s, ox, oy, oz, fov;
    logic [31:0] theta, phi, sum;
    px = longint'(q.px); py = longint'(q.py); pz = longint'(q.pz);
    dx = longint'(q.ax) - px;
    dy = longint'(q.ay) - py;
    dz = longint'(q.az) - pz;
    stf = longint'(q.stf);
    adv = longint'(q.adv);
    // move along and across the view offset
    npx = clamp32(px + ((dx * adv + stf * dz + 64'sd8192) >>> 14));
    npy = clamp32(py + ((dy * adv + 64'sd8192) >>> 14));
    npz = clamp32(pz + ((dz * adv - stf * dx + 64'sd8192) >>> 14));
    // offset to spherical form
    polar_of(dx, dz, mag, theta);
    rho = unscale_gain(mag);
    polar_of(dy, rho, mag, phi);
    rad = unscale_gain(mag);
    sum = theta + rad_to_angle(longint'(q.yaw));
    theta = sum;
    sum = phi + rad_to_angle(longint'(q.pit));
    phi = sum;
    // back to cartesian
    rotate_by(rad, phi, c, s);
    oy = unscale_gain(c);
    s = unscale_gain(s);
    rotate_by(s, theta, c, mag);
    ox = unscale_gain(c);
    oz = unscale_gain(mag);
    fov = longint'(fov_base) + longint'(q.fdel);
    if (fov < 0) fov = 0;
    if (fov > 65535) fov = 65535;
    e.npx = npx[31:0];
    e.npy = npy[31:0];
    e.npz = npz[31:0];
    e.nax = 32'(clamp32(npx + ox));
    e.nay = 32'(clamp32(npy + oy));
    e.naz = 32'(clamp32(npz + oz));
    e.fov = fov[15:0];
  endtask

  // ---------------- request driver ----------------
  always @(posedge clk) begin
    pose_res_t e;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_pose(drv_req, e);
        expected_poses.push_back(e);
      end
      if (!quiet && gap_left == 0 && $urandom_range(0, 7) == 0)
        gap_left = $urandom_range(1, 6);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        drv_req <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- result monitor ----------------
  always @(posedge clk) begin
    pose_res_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: %h", dut_res);
        end else begin
          e = expected_poses.pop_front();
          if (e != dut_res) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch pos exp %h %h %h got %h %h %h",
                       e.npx, e.npy, e.npz, dut_res.npx, dut_res.npy, dut_res.npz);
              $display("  aim exp %h %h %h got %h %h %h fov exp %h got %h",
                       e.nax, e.nay, e.naz, dut_res.nax, dut_res.nay, dut_res.naz,
                       e.fov, dut_res.fov);
            end
          end
        end
      end
      if (!quiet && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 6);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------

  function automatic pose_req_t rand_pose(input bit wide);
    pose_req_t q;
    q.stf = 16'($urandom);
    q.adv = 16'($urandom);
    q.yaw = 16'($urandom);
    q.pit = 16'($urandom);
    q.fdel = 16'($urandom);
    if (wide) begin
      q.px = $urandom; q.py = $urandom; q.pz = $urandom;
      q.ax = $urandom; q.ay = $urandom; q.az = $urandom;
    end else begin
      // typical scene: camera near its focus
      q.px = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      q.py = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      q.pz = $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      q.ax = q.px + $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      q.ay = q.py + $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      q.az = q.pz + $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
    end
    return q;
  endfunction

  function automatic pose_req_t make_pose(input int x, y, z, input int dx, dy, dz,
                                          input int stf, adv, yaw, pit, fdel);
    pose_req_t q;
    q.px = x; q.py = y; q.pz = z;
    q.ax = x + dx; q.ay = y + dy; q.az = z + dz;
    q.stf = stf[15:0]; q.adv = adv[15:0];
    q.yaw = yaw[15:0]; q.pit = pit[15:0]; q.fdel = fdel[15:0];
    return q;
  endfunction

  // checked between edges so that all updates of the edge have landed
  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_poses.size() > 0)
      @(negedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_start_fov(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    fov_base = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    pose_req_t q;
    logic [15:0] fov_set [5];
    fov_set = '{16'h0000, 16'hFFFF, 16'h1000, 16'h8000, 16'h3243};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners, run twice at both fov extremes
    for (int p = 0; p < 2; p++) begin
      write_start_fov(p ? 16'hFFFF : 16'h0000);
      // zero offset
      pending_reqs.push_back(make_pose(65536, 0, -65536, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(make_pose(0, 0, 0, 0, 0, 0, 32767, -32768, 32767, -32768, -32768));
      // offset along +x, in the two left quadrants of the x-z plane and along -z
      pending_reqs.push_back(make_pose(0, 0, 0, 65536, 0, 0, 0, 16384, 0, 0, 32767));
      pending_reqs.push_back(make_pose(0, 0, 0, -65536, 0, 65536, 8192, 0, 12868, 0, 100));
      pending_reqs.push_back(make_pose(0, 0, 0, -65536, 65536, -65536, -8192, 0, 0, 25736, -100));
      pending_reqs.push_back(make_pose(0, 0, 0, 0, -131072, -65536, 0, 0, -25736, -12868, 0));
      // angle wrap with full-scale steps
      pending_reqs.push_back(make_pose(100, 200, 300, 70000, -70000, 70000,
                                       0, 0, 32767, 32767, 0));
      pending_reqs.push_back(make_pose(100, 200, 300, -70000, 70000, -70000,
                                       0, 0, -32768, -32768, 0));
      // overflow of position and focus
      q.px = 32'sh7FFFFFFF; q.py = 32'sh80000000; q.pz = 32'sh7FFFFFFF;
      q.ax = 32'sh80000000; q.ay = 32'sh7FFFFFFF; q.az = 32'sh80000000;
      q.stf = 16'sh7FFF; q.adv = 16'sh8000; q.yaw = 16'sh7FFF; q.pit = 16'sh8000;
      q.fdel = 16'sh7FFF;
      pending_reqs.push_back(q);
      q.ax = 32'sh7FFFFFFF; q.ay = 32'sh80000000; q.az = 32'sh7FFFFFFF;
      q.px = 32'sh80000000; q.py = 32'sh7FFFFFFF; q.pz = 32'sh80000000;
      q.stf = 16'sh8000; q.adv = 16'sh7FFF; q.fdel = 16'sh8000;
      pending_reqs.push_back(q);
      q.px = 32'sh7FFFFFFF; q.py = 32'sh7FFFFFFF; q.pz = 32'sh7FFFFFFF;
      q.ax = 32'sh7FFFFFFF; q.ay = 32'sh7FFFFFFF; q.az = 32'sh7FFFFFFF;
      q.adv = 16'sh7FFF; q.stf = 16'sh7FFF;
      pending_reqs.push_back(q);
      wait_drained();
    end

    // random phases over several start fov settings; the last one runs without idling
    for (int p = 0; p < 5; p++) begin
      write_start_fov(p < 3 ? fov_set[p[2:0]] : 16'($urandom));
      if (p == 4) quiet = 1'b1;
      for (int i = 0; i < 105; i++)
        pending_reqs.push_back(rand_pose($urandom_range(0, 3) == 0));
      wait_drained();
    end

    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
